@@ design/gda_pkg.sv @@
// Shared types, constants and calendar functions for the date offset block.
// Depends on nothing; used by every other file of the block.
`default_nettype none

package gda_pkg;

  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned DoyW    = 9;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned CentW   = 7;
  localparam int unsigned CountW  = 16;
  localparam int unsigned MulAW   = 14;
  localparam int unsigned MulBW   = 15;
  localparam int unsigned MulPW   = MulAW + MulBW;
  localparam int unsigned QuotW   = 11;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthMar = 4'd3;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [YearW-1:0]  YearMin  = 14'd1;
  localparam logic [YearW-1:0]  YearMax  = 14'd9999;
  localparam logic [CentW-1:0]  LastInCentury = 7'd99;

  localparam logic [MulBW-1:0] Recip100      = 15'd10486;
  localparam int unsigned      Recip100Shift = 20;
  localparam logic [MulBW-1:0] Recip7        = 15'd18725;
  localparam int unsigned      Recip7Shift   = 17;
  localparam logic [MulBW-1:0] Mul100        = 15'd100;
  localparam logic [MulBW-1:0] Mul7          = 15'd7;

  typedef struct packed {
    logic [DayW-1:0]   rd;
    logic [MonthW-1:0] rm;
    logic [YearW-1:0]  ry;
    logic [CentW-1:0]  r100;
    logic [CentW-1:0]  cent;
    logic [CountW-1:0] n;
    logic              back;
  } step_t;

  typedef struct packed {
    step_t nxt;
    logic  err;
  } step_res_t;

  function automatic logic is_leap(input logic [1:0] ylo, input logic [CentW-1:0] r100,
                                   input logic [CentW-1:0] cent);
    return ((ylo == 2'd0) && (r100 != '0)) || ((r100 == '0) && (cent[1:0] == 2'd0));
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] r;
    case (m)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] sakamoto(input logic [MonthW-1:0] m);
    logic [2:0] r;
    case (m)
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/gda_in_if.sv @@
// Input channel: start date and signed day offset with valid/ready.
// Depends on gda_pkg for the field widths.
`default_nettype none

interface gda_in_if;
  logic                                valid;
  logic                                ready;
  logic [gda_pkg::DayW-1:0]            start_day;
  logic [gda_pkg::MonthW-1:0]          start_month;
  logic [gda_pkg::YearW-1:0]           start_year;
  logic signed [gda_pkg::OffsetW-1:0]  day_offset;

  modport source (output valid, start_day, start_month, start_year, day_offset,
                  input ready);
  modport sink   (input valid, start_day, start_month, start_year, day_offset,
                  output ready);
endinterface

`default_nettype wire

@@ design/gda_out_if.sv @@
// Output channel: resulting date, ordinal day, weekday and range flag.
// Depends on gda_pkg for the field widths.
`default_nettype none

interface gda_out_if;
  logic                        valid;
  logic                        ready;
  logic [gda_pkg::DayW-1:0]    new_day;
  logic [gda_pkg::MonthW-1:0]  new_month;
  logic [gda_pkg::YearW-1:0]   new_year;
  logic [gda_pkg::DoyW-1:0]    day_of_year;
  logic [gda_pkg::WdayW-1:0]   weekday;
  logic                        range_error;

  modport source (output valid, new_day, new_month, new_year, day_of_year, weekday,
                  range_error, input ready);
  modport sink   (input valid, new_day, new_month, new_year, day_of_year, weekday,
                  range_error, output ready);
endinterface

`default_nettype wire

@@ design/gda_step.sv @@
// Month stepping unit: advances or rewinds the working date by one month or
// finishes the offset inside the current month. Depends on gda_pkg.
`default_nettype none

module gda_step (
  input  wire gda_pkg::step_t cur_i,
  output gda_pkg::step_res_t  res_o
);

  logic                         leap;
  logic [gda_pkg::DayW-1:0]     dim;
  logic [gda_pkg::DayW-1:0]     rest;
  logic [gda_pkg::MonthW-1:0]   prev_m;

  assign leap   = gda_pkg::is_leap(cur_i.ry[1:0], cur_i.r100, cur_i.cent);
  assign dim    = gda_pkg::month_days(cur_i.rm, leap);
  assign rest   = dim - cur_i.rd;
  assign prev_m = cur_i.rm - 4'd1;

  always_comb begin
    res_o.nxt = cur_i;
    res_o.err = 1'b0;
    if (!cur_i.back) begin
      if (cur_i.n <= gda_pkg::CountW'(rest)) begin
        res_o.nxt.rd = cur_i.rd + cur_i.n[gda_pkg::DayW-1:0];
        res_o.nxt.n  = '0;
      end else begin
        res_o.nxt.n  = cur_i.n - gda_pkg::CountW'(rest) - 16'd1;
        res_o.nxt.rd = 5'd1;
        if (cur_i.rm == gda_pkg::MonthDec) begin
          res_o.nxt.rm = gda_pkg::MonthJan;
          res_o.nxt.ry = cur_i.ry + 14'd1;
          res_o.err    = (cur_i.ry >= gda_pkg::YearMax);
          if (cur_i.r100 == gda_pkg::LastInCentury) begin
            res_o.nxt.r100 = '0;
            res_o.nxt.cent = cur_i.cent + 7'd1;
          end else begin
            res_o.nxt.r100 = cur_i.r100 + 7'd1;
          end
        end else begin
          res_o.nxt.rm = cur_i.rm + 4'd1;
        end
      end
    end else begin
      if (cur_i.n < gda_pkg::CountW'(cur_i.rd)) begin
        res_o.nxt.rd = cur_i.rd - cur_i.n[gda_pkg::DayW-1:0];
        res_o.nxt.n  = '0;
      end else begin
        res_o.nxt.n = cur_i.n - gda_pkg::CountW'(cur_i.rd);
        if (cur_i.rm == gda_pkg::MonthJan) begin
          res_o.nxt.rm = gda_pkg::MonthDec;
          res_o.nxt.rd = 5'd31;
          res_o.err    = (cur_i.ry <= gda_pkg::YearMin);
          res_o.nxt.ry = cur_i.ry - 14'd1;
          if (cur_i.r100 == '0) begin
            res_o.nxt.r100 = gda_pkg::LastInCentury;
            res_o.nxt.cent = cur_i.cent - 7'd1;
          end else begin
            res_o.nxt.r100 = cur_i.r100 - 7'd1;
          end
        end else begin
          res_o.nxt.rm = prev_m;
          res_o.nxt.rd = gda_pkg::month_days(prev_m, leap);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ design/gregorian_date_add_days.sv @@
// Top level of the Gregorian date offset block: sequencer, shared multiplier
// and output register. Depends on gda_pkg, gda_in_if, gda_out_if and gda_step.
//
// Each transfer on the input carries a start date and a signed day offset; one
// result transfer follows with the moved date, its day of the year, its weekday
// (0 is Sunday) and a range flag. Out-of-range start fields are first clamped
// to a valid date. The date moves one month per clock cycle in the month
// stepping loop; the clamping and the weekday are done before and after that
// loop, respectively, on one shared multiplier. The input is ready only while
// no item is in work; a finished result waits in the output register while
// the next item is taken in.
`default_nettype none

module gregorian_date_add_days (
  input  wire           clk_i,
  input  wire           rst_ni,
  gda_in_if.sink        in_i,
  gda_out_if.source     out_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StNorm0 = 3'd1;
  localparam logic [2:0] StNorm1 = 3'd2;
  localparam logic [2:0] StNorm2 = 3'd3;
  localparam logic [2:0] StStep  = 3'd4;
  localparam logic [2:0] StFin0  = 3'd5;
  localparam logic [2:0] StFin1  = 3'd6;
  localparam logic [2:0] StFin2  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       fin3_q, fin3_d;
  logic       out_valid_q, out_valid_d;

  logic [gda_pkg::DayW-1:0]    raw_d_q;
  logic [gda_pkg::MonthW-1:0]  raw_m_q;
  logic [gda_pkg::YearW-1:0]   raw_y_q;
  gda_pkg::step_t              cur_q;
  gda_pkg::step_t              start_q;
  logic                        err_q;
  logic [gda_pkg::QuotW-1:0]   quot_q;
  logic [gda_pkg::YearW-1:0]   sum_q;
  logic [gda_pkg::DoyW-1:0]    doy_q;

  logic [gda_pkg::DayW-1:0]    o_day_q;
  logic [gda_pkg::MonthW-1:0]  o_month_q;
  logic [gda_pkg::YearW-1:0]   o_year_q;
  logic [gda_pkg::DoyW-1:0]    o_doy_q;
  logic [gda_pkg::WdayW-1:0]   o_wday_q;
  logic                        o_err_q;

  logic [gda_pkg::MulAW-1:0]   mul_a;
  logic [gda_pkg::MulBW-1:0]   mul_b;
  logic [gda_pkg::MulPW-1:0]   mul_p;

  logic [gda_pkg::MonthW-1:0]  m_cl;
  logic [gda_pkg::YearW-1:0]   y_cl;
  logic [gda_pkg::CountW-1:0]  n_abs;
  logic                        cur_leap;
  logic [gda_pkg::DayW-1:0]    cur_dim;
  logic [gda_pkg::YearW-1:0]   adj_y;
  logic [gda_pkg::YearW-1:0]   wsum;
  logic [gda_pkg::YearW-1:0]   wrem;
  logic                        in_xfer;
  logic                        out_free;
  gda_pkg::step_res_t          step_res;

  gda_step u_step (
    .cur_i (cur_q),
    .res_o (step_res)
  );

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == StIdle) && !fin3_q;

  assign m_cl = (raw_m_q == '0) ? gda_pkg::MonthJan :
                (raw_m_q > gda_pkg::MonthDec) ? gda_pkg::MonthDec : raw_m_q;
  assign y_cl = (raw_y_q == '0) ? gda_pkg::YearMin :
                (raw_y_q > gda_pkg::YearMax) ? gda_pkg::YearMax : raw_y_q;

  assign n_abs = in_i.day_offset[gda_pkg::OffsetW-1] ?
                 gda_pkg::CountW'(~in_i.day_offset + 16'sd1) :
                 gda_pkg::CountW'(in_i.day_offset);

  assign cur_leap = gda_pkg::is_leap(cur_q.ry[1:0], cur_q.r100, cur_q.cent);
  assign cur_dim  = gda_pkg::month_days(cur_q.rm, cur_leap);
  assign adj_y    = (cur_q.rm < gda_pkg::MonthMar) ? cur_q.ry - 14'd1 : cur_q.ry;

  assign wsum = adj_y + (adj_y >> 2) - gda_pkg::YearW'(quot_q)
              + gda_pkg::YearW'(quot_q >> 2)
              + gda_pkg::YearW'(gda_pkg::sakamoto(cur_q.rm))
              + gda_pkg::YearW'(cur_q.rd);
  assign wrem = sum_q - mul_p[gda_pkg::YearW-1:0];

  // One multiplier serves the reciprocal divisions and their remainders.
  always_comb begin
    mul_a = adj_y;
    mul_b = gda_pkg::Recip100;
    if (fin3_q) begin
      mul_a = gda_pkg::MulAW'(quot_q);
      mul_b = gda_pkg::Mul7;
    end else begin
      case (state_q)
        StNorm0: begin
          mul_a = y_cl;
          mul_b = gda_pkg::Recip100;
        end
        StNorm1: begin
          mul_a = gda_pkg::MulAW'(quot_q);
          mul_b = gda_pkg::Mul100;
        end
        StFin2: begin
          mul_a = sum_q;
          mul_b = gda_pkg::Recip7;
        end
        default: begin
          mul_a = adj_y;
          mul_b = gda_pkg::Recip100;
        end
      endcase
    end
  end

  assign mul_p = gda_pkg::MulPW'(mul_a) * gda_pkg::MulPW'(mul_b);

  always_comb begin
    state_d     = state_q;
    fin3_d      = fin3_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (fin3_q) begin
      if (out_free) begin
        fin3_d      = 1'b0;
        out_valid_d = 1'b1;
      end
    end else begin
      case (state_q)
        StIdle:  if (in_xfer) state_d = StNorm0;
        StNorm0: state_d = StNorm1;
        StNorm1: state_d = StNorm2;
        StNorm2: state_d = StStep;
        StStep:  if ((cur_q.n == '0) || step_res.err) state_d = StFin0;
        StFin0:  state_d = StFin1;
        StFin1:  state_d = StFin2;
        StFin2: begin
          state_d = StIdle;
          fin3_d  = 1'b1;
        end
        default: state_d = StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fin3_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin3_q      <= fin3_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      raw_d_q    <= in_i.start_day;
      raw_m_q    <= in_i.start_month;
      raw_y_q    <= in_i.start_year;
      cur_q.n    <= n_abs;
      cur_q.back <= in_i.day_offset[gda_pkg::OffsetW-1];
      err_q      <= 1'b0;
    end
    if (!fin3_q) begin
      case (state_q)
        StNorm0: begin
          cur_q.rm <= m_cl;
          cur_q.ry <= y_cl;
          cur_q.rd <= (raw_d_q == '0) ? 5'd1 : raw_d_q;
          quot_q   <= gda_pkg::QuotW'(mul_p[gda_pkg::Recip100Shift +: gda_pkg::CentW]);
        end
        StNorm1: begin
          cur_q.r100 <= gda_pkg::CentW'(cur_q.ry - mul_p[gda_pkg::YearW-1:0]);
          cur_q.cent <= gda_pkg::CentW'(quot_q);
        end
        StNorm2: begin
          if (cur_q.rd > cur_dim) begin
            cur_q.rd   <= cur_dim;
            start_q.rd <= cur_dim;
          end else begin
            start_q.rd <= cur_q.rd;
          end
          start_q.rm   <= cur_q.rm;
          start_q.ry   <= cur_q.ry;
          start_q.r100 <= cur_q.r100;
          start_q.cent <= cur_q.cent;
          start_q.n    <= cur_q.n;
          start_q.back <= cur_q.back;
        end
        StStep: begin
          if (cur_q.n != '0) begin
            if (step_res.err) begin
              err_q <= 1'b1;
              cur_q <= start_q;
            end else begin
              cur_q <= step_res.nxt;
            end
          end
        end
        StFin0: begin
          quot_q <= gda_pkg::QuotW'(mul_p[gda_pkg::Recip100Shift +: gda_pkg::CentW]);
          doy_q  <= gda_pkg::days_before(cur_q.rm) + gda_pkg::DoyW'(cur_q.rd)
                  + gda_pkg::DoyW'(cur_leap && (cur_q.rm > gda_pkg::MonthFeb));
        end
        StFin1: begin
          sum_q <= wsum;
        end
        StFin2: begin
          quot_q <= mul_p[gda_pkg::Recip7Shift +: gda_pkg::QuotW];
        end
        default: begin
        end
      endcase
    end
    if (fin3_q && out_free) begin
      o_day_q   <= cur_q.rd;
      o_month_q <= cur_q.rm;
      o_year_q  <= cur_q.ry;
      o_doy_q   <= doy_q;
      o_wday_q  <= wrem[gda_pkg::WdayW-1:0];
      o_err_q   <= err_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.new_day     = o_day_q;
  assign out_o.new_month   = o_month_q;
  assign out_o.new_year    = o_year_q;
  assign out_o.day_of_year = o_doy_q;
  assign out_o.weekday     = o_wday_q;
  assign out_o.range_error = o_err_q;

endmodule

`default_nettype wire

@@ verif/gregorian_date_add_days_tb.sv @@
// Self-checking testbench for the Gregorian date offset block.
// Depends on gda_pkg, gda_in_if, gda_out_if and the gregorian_date_add_days top level.
// A built-in date stepper predicts each result; a monitor compares every output transfer.

module gregorian_date_add_days_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RandomItems = 540;
  localparam int          DrainCycles = 1200;
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int          YearFirst   = 1;
  localparam int          YearLast    = 9999;
  localparam int          MonthsInYear = 12;
  localparam int          DaysInWeek  = 7;

  // Weekday month offsets, January in the low nibble.
  localparam logic [47:0] SakamotoCodes = 48'h426_415_305_230;

  typedef struct packed {
    logic [gda_pkg::DayW-1:0]           day;
    logic [gda_pkg::MonthW-1:0]         month;
    logic [gda_pkg::YearW-1:0]          year;
    logic signed [gda_pkg::OffsetW-1:0] offset;
  } date_req_t;

  typedef struct packed {
    logic [gda_pkg::DayW-1:0]   day;
    logic [gda_pkg::MonthW-1:0] month;
    logic [gda_pkg::YearW-1:0]  year;
    logic [gda_pkg::DoyW-1:0]   doy;
    logic [gda_pkg::WdayW-1:0]  wday;
    logic                       range_err;
  } date_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        send_valid = 1'b0;
  date_req_t   send_req = '0;
  logic        take_ready = 1'b0;

  date_req_t   pending_shifts[$];
  date_res_t   expected_dates[$];
  date_req_t   driven_req;
  date_res_t   want;
  int          burst_left;
  int          gap_left;
  logic [7:0]  ready_pattern;
  int          pattern_age;
  int          fail_cnt = 0;
  int unsigned cycle_cnt;

  gda_in_if  in_if ();
  gda_out_if out_if ();

  assign in_if.valid       = send_valid;
  assign in_if.start_day   = send_req.day;
  assign in_if.start_month = send_req.month;
  assign in_if.start_year  = send_req.year;
  assign in_if.day_offset  = send_req.offset;
  assign out_if.ready      = take_ready;

  gregorian_date_add_days dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  function automatic bit leap_year_at(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(int m, int y);
    if (m == 2) begin
      return leap_year_at(y) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic date_res_t shift_date(date_req_t r);
    date_res_t res;
    int d, m, y, off, n, rd, rm, ry, rest, doy, a, sak, wd;
    bit back, err;
    d = int'(r.day);
    m = int'(r.month);
    y = int'(r.year);
    off = int'($signed(r.offset));
    back = off < 0;
    n = back ? -off : off;
    err = 1'b0;
    if (m < 1) m = 1;
    if (m > MonthsInYear) m = MonthsInYear;
    if (y < YearFirst) y = YearFirst;
    if (y > YearLast) y = YearLast;
    if (d < 1) d = 1;
    if (d > month_length(m, y)) d = month_length(m, y);
    rd = d;
    rm = m;
    ry = y;
    while (n > 0 && !err) begin
      if (!back) begin
        rest = month_length(rm, ry) - rd;
        if (n <= rest) begin
          rd = rd + n;
          n = 0;
        end else begin
          n = n - (rest + 1);
          rd = 1;
          if (rm == MonthsInYear) begin
            rm = 1;
            ry = ry + 1;
            if (ry > YearLast) err = 1'b1;
          end else begin
            rm = rm + 1;
          end
        end
      end else begin
        if (n < rd) begin
          rd = rd - n;
          n = 0;
        end else begin
          n = n - rd;
          if (rm == 1) begin
            rm = MonthsInYear;
            if (ry <= YearFirst) err = 1'b1;
            else ry = ry - 1;
          end else begin
            rm = rm - 1;
          end
          if (!err) rd = month_length(rm, ry);
        end
      end
    end
    if (err) begin
      rd = d;
      rm = m;
      ry = y;
    end
    doy = rd;
    for (int k = 1; k < rm; k++) begin
      doy = doy + month_length(k, ry);
    end
    a = (rm < 3) ? ry - 1 : ry;
    sak = int'((SakamotoCodes >> (4 * (rm - 1))) & 48'hF);
    wd = (a + a / 4 - a / 100 + a / 400 + sak + rd) % DaysInWeek;
    res.day       = rd[gda_pkg::DayW-1:0];
    res.month     = rm[gda_pkg::MonthW-1:0];
    res.year      = ry[gda_pkg::YearW-1:0];
    res.doy       = doy[gda_pkg::DoyW-1:0];
    res.wday      = wd[gda_pkg::WdayW-1:0];
    res.range_err = err;
    return res;
  endfunction

  function automatic date_req_t make_req(int d, int m, int y, int off);
    date_req_t r;
    r.day    = d[gda_pkg::DayW-1:0];
    r.month  = m[gda_pkg::MonthW-1:0];
    r.year   = y[gda_pkg::YearW-1:0];
    r.offset = off[gda_pkg::OffsetW-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
      fail_cnt++;
    end
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_valid <= 1'b0;
      send_req <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (send_valid && in_if.ready) begin
        expected_dates.push_back(shift_date(driven_req));
      end
      if (!send_valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          send_valid <= 1'b0;
        end else if (pending_shifts.size() > 0) begin
          driven_req = pending_shifts.pop_front();
          send_valid <= 1'b1;
          send_req <= driven_req;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_ready <= 1'b0;
      ready_pattern = 8'hFF;
      pattern_age = 0;
    end else begin
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = 8'hFF;
          1: ready_pattern = 8'h01;
          default: ready_pattern = 8'($urandom_range(1, 255));
        endcase
        pattern_age = $urandom_range(20, 200);
      end else begin
        pattern_age--;
      end
      take_ready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && take_ready) begin
      if (expected_dates.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual %0d-%0d-%0d", $time,
                 out_if.new_year, out_if.new_month, out_if.new_day);
        fail_cnt++;
      end else begin
        want = expected_dates.pop_front();
        check_field("new_day", int'(want.day), int'(out_if.new_day));
        check_field("new_month", int'(want.month), int'(out_if.new_month));
        check_field("new_year", int'(want.year), int'(out_if.new_year));
        check_field("day_of_year", int'(want.doy), int'(out_if.day_of_year));
        check_field("weekday", int'(want.wday), int'(out_if.weekday));
        check_field("range_error", int'(want.range_err), int'(out_if.range_error));
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int d, m, y, off, pick;

    pending_shifts.push_back(make_req(1, 1, 1, 0));
    pending_shifts.push_back(make_req(31, 12, 9999, 1));
    pending_shifts.push_back(make_req(1, 1, 1, -1));
    pending_shifts.push_back(make_req(28, 2, 1900, 1));
    pending_shifts.push_back(make_req(28, 2, 2000, 1));
    pending_shifts.push_back(make_req(29, 2, 2024, 365));
    pending_shifts.push_back(make_req(0, 0, 0, 0));
    pending_shifts.push_back(make_req(31, 15, 16383, -1));
    pending_shifts.push_back(make_req(31, 2, 2023, 0));
    pending_shifts.push_back(make_req(30, 2, 2024, 0));
    pending_shifts.push_back(make_req(31, 4, 2021, 1));
    pending_shifts.push_back(make_req(1, 1, 2000, 32767));
    pending_shifts.push_back(make_req(31, 12, 2000, -32768));
    pending_shifts.push_back(make_req(1, 1, 9990, 32767));
    pending_shifts.push_back(make_req(15, 6, 50, -32768));
    pending_shifts.push_back(make_req(31, 12, 1999, 1));
    pending_shifts.push_back(make_req(1, 1, 2000, -1));
    pending_shifts.push_back(make_req(1, 3, 2100, -1));
    pending_shifts.push_back(make_req(1, 3, 2400, -1));
    pending_shifts.push_back(make_req(31, 12, 9998, 365));
    pending_shifts.push_back(make_req(31, 12, 9998, 366));
    pending_shifts.push_back(make_req(1, 1, 2, -365));
    pending_shifts.push_back(make_req(1, 1, 2, -366));
    pending_shifts.push_back(make_req(17, 13, 10000, 21845));
    pending_shifts.push_back(make_req(31, 8, 8191, -21846));

    for (int i = 0; i < RandomItems; i++) begin
      pick = $urandom_range(0, 99);
      d = $urandom_range(1, 31);
      m = $urandom_range(1, 12);
      y = $urandom_range(YearFirst, YearLast);
      off = int'($urandom_range(0, 2000)) - 1000;
      if (pick < 8) begin
        y = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 40) : $urandom_range(9960, 9999);
        off = int'($urandom_range(0, 30000)) - 15000;
      end else if (pick < 18) begin
        off = int'($urandom_range(0, 65535)) - 32768;
      end else if (pick < 28) begin
        d = $urandom_range(0, 31);
        m = $urandom_range(0, 15);
        y = $urandom_range(0, 16383);
        off = int'($urandom_range(0, 20000)) - 10000;
      end else if (pick < 38) begin
        d = $urandom_range(27, 31);
        off = int'($urandom_range(0, 80)) - 40;
      end
      pending_shifts.push_back(make_req(d, m, y, off));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_shifts.size() != 0 || send_valid) @(posedge clk_i);
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/gda_pkg.sv
design/gda_in_if.sv
design/gda_out_if.sv
design/gda_step.sv
design/gregorian_date_add_days.sv
verif/gregorian_date_add_days_tb.sv
